>>> rtl/pcs_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcs_pkg
// Shared types, constants and the compensation microprogram for the
// pressure / temperature compensation block.
// ---------------------------------------------------------------------------
package pcs_pkg;

   localparam int WORD_W    = 64;
   localparam int HALF_W    = 32;
   localparam int RAW_W     = 20;
   localparam int COEF_W    = 48;
   localparam int CW_W      = 16;
   localparam int TEMP_W    = 24;
   localparam int PRESS_W   = 32;
   localparam int FINE_W    = 32;
   localparam int PC_W      = 6;
   localparam int STEP_W    = 7;
   localparam int SH_W      = 6;
   localparam int CSR_IDX_W = 2;

   // last step of the multi-cycle operations
   localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(2);
   localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(WORD_W + 1);

   // microprogram entry points
   localparam logic [PC_W-1:0] PC_TEMP  = PC_W'(0);
   localparam logic [PC_W-1:0] PC_PRESS = PC_W'(17);
   localparam logic [PC_W-1:0] PC_DZ    = PC_W'(51);
   localparam logic [PC_W-1:0] PC_LAST  = PC_W'(51);

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_P_LOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_P_MID  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_P_HIGH = 2'd3;

   typedef enum logic [3:0] {
      OP_ADD, OP_SUB, OP_MUL, OP_ASR, OP_SHL, OP_DIV,
      OP_FINE, OP_BZ, OP_END_T, OP_END_P, OP_END_Z
   } op_type;

   typedef enum logic [4:0] {
      SRC_R0, SRC_R1, SRC_R2, SRC_R3, SRC_ADC,
      SRC_T1, SRC_T2, SRC_T3,
      SRC_P1, SRC_P2, SRC_P3, SRC_P4, SRC_P5, SRC_P6, SRC_P7, SRC_P8, SRC_P9,
      SRC_TFINE, SRC_K128000, SRC_K1048576, SRC_K3125, SRC_K5, SRC_K128,
      SRC_K2P47, SRC_ZERO
   } src_type;

   typedef enum logic [1:0] {RG0, RG1, RG2, RG3} reg_type;

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   typedef struct packed {
      op_type            op;
      reg_type           dst;
      src_type           a;
      src_type           b;
      logic [SH_W-1:0]   sh;
   } instr_type;

   typedef struct packed {
      logic              run;
      logic              load_req;
      instr_type         instr;
      logic [STEP_W-1:0] step;
   } cmd_type;

   typedef struct packed {
      logic a_zero;
   } status_type;

   function automatic instr_type mk(op_type op, reg_type dst, src_type a, src_type b,
                                    int sh);
      instr_type i;
      i.op  = op;
      i.dst = dst;
      i.a   = a;
      i.b   = b;
      i.sh  = SH_W'(sh);
      return i;
   endfunction

   // compensation microprogram
   function automatic instr_type prog(logic [PC_W-1:0] pc);
      instr_type i;
      unique case (pc)
         // temperature
         6'd0:  i = mk(OP_ASR, RG0, SRC_ADC, SRC_ZERO, 3);
         6'd1:  i = mk(OP_SHL, RG1, SRC_T1, SRC_ZERO, 1);
         6'd2:  i = mk(OP_SUB, RG0, SRC_R0, SRC_R1, 0);
         6'd3:  i = mk(OP_MUL, RG0, SRC_R0, SRC_T2, 0);
         6'd4:  i = mk(OP_ASR, RG0, SRC_R0, SRC_ZERO, 11);
         6'd5:  i = mk(OP_ASR, RG1, SRC_ADC, SRC_ZERO, 4);
         6'd6:  i = mk(OP_SUB, RG1, SRC_R1, SRC_T1, 0);
         6'd7:  i = mk(OP_MUL, RG1, SRC_R1, SRC_R1, 0);
         6'd8:  i = mk(OP_ASR, RG1, SRC_R1, SRC_ZERO, 12);
         6'd9:  i = mk(OP_MUL, RG1, SRC_R1, SRC_T3, 0);
         6'd10: i = mk(OP_ASR, RG1, SRC_R1, SRC_ZERO, 14);
         6'd11: i = mk(OP_ADD, RG0, SRC_R0, SRC_R1, 0);
         6'd12: i = mk(OP_FINE, RG0, SRC_R0, SRC_ZERO, 0);
         6'd13: i = mk(OP_MUL, RG0, SRC_TFINE, SRC_K5, 0);
         6'd14: i = mk(OP_ADD, RG0, SRC_R0, SRC_K128, 0);
         6'd15: i = mk(OP_ASR, RG0, SRC_R0, SRC_ZERO, 8);
         6'd16: i = mk(OP_END_T, RG0, SRC_R0, SRC_ZERO, 0);
         // pressure: denominator
         6'd17: i = mk(OP_SUB, RG0, SRC_TFINE, SRC_K128000, 0);
         6'd18: i = mk(OP_MUL, RG1, SRC_R0, SRC_R0, 0);
         6'd19: i = mk(OP_MUL, RG2, SRC_R1, SRC_P6, 0);
         6'd20: i = mk(OP_MUL, RG3, SRC_R0, SRC_P5, 0);
         6'd21: i = mk(OP_SHL, RG3, SRC_R3, SRC_ZERO, 17);
         6'd22: i = mk(OP_ADD, RG2, SRC_R2, SRC_R3, 0);
         6'd23: i = mk(OP_SHL, RG3, SRC_P4, SRC_ZERO, 35);
         6'd24: i = mk(OP_ADD, RG2, SRC_R2, SRC_R3, 0);
         6'd25: i = mk(OP_MUL, RG1, SRC_R1, SRC_P3, 0);
         6'd26: i = mk(OP_ASR, RG1, SRC_R1, SRC_ZERO, 8);
         6'd27: i = mk(OP_MUL, RG3, SRC_R0, SRC_P2, 0);
         6'd28: i = mk(OP_SHL, RG3, SRC_R3, SRC_ZERO, 12);
         6'd29: i = mk(OP_ADD, RG1, SRC_R1, SRC_R3, 0);
         6'd30: i = mk(OP_ADD, RG1, SRC_K2P47, SRC_R1, 0);
         6'd31: i = mk(OP_MUL, RG1, SRC_R1, SRC_P1, 0);
         6'd32: i = mk(OP_ASR, RG1, SRC_R1, SRC_ZERO, 33);
         6'd33: i = mk(OP_BZ, RG1, SRC_R1, SRC_ZERO, 0);
         // pressure: quotient and correction
         6'd34: i = mk(OP_SUB, RG0, SRC_K1048576, SRC_ADC, 0);
         6'd35: i = mk(OP_SHL, RG0, SRC_R0, SRC_ZERO, 31);
         6'd36: i = mk(OP_SUB, RG0, SRC_R0, SRC_R2, 0);
         6'd37: i = mk(OP_MUL, RG0, SRC_R0, SRC_K3125, 0);
         6'd38: i = mk(OP_DIV, RG0, SRC_R0, SRC_R1, 0);
         6'd39: i = mk(OP_ASR, RG3, SRC_R0, SRC_ZERO, 13);
         6'd40: i = mk(OP_MUL, RG2, SRC_P9, SRC_R3, 0);
         6'd41: i = mk(OP_MUL, RG2, SRC_R2, SRC_R3, 0);
         6'd42: i = mk(OP_ASR, RG2, SRC_R2, SRC_ZERO, 25);
         6'd43: i = mk(OP_MUL, RG1, SRC_P8, SRC_R0, 0);
         6'd44: i = mk(OP_ASR, RG1, SRC_R1, SRC_ZERO, 19);
         6'd45: i = mk(OP_ADD, RG0, SRC_R0, SRC_R2, 0);
         6'd46: i = mk(OP_ADD, RG0, SRC_R0, SRC_R1, 0);
         6'd47: i = mk(OP_ASR, RG0, SRC_R0, SRC_ZERO, 8);
         6'd48: i = mk(OP_SHL, RG1, SRC_P7, SRC_ZERO, 4);
         6'd49: i = mk(OP_ADD, RG0, SRC_R0, SRC_R1, 0);
         6'd50: i = mk(OP_END_P, RG0, SRC_R0, SRC_ZERO, 0);
         default: i = mk(OP_END_Z, RG0, SRC_ZERO, SRC_ZERO, 0);
      endcase
      return i;
   endfunction

endpackage

>>> rtl/pressure_temp_compensation.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pressure_temp_compensation
// Barometric sensor compensation: raw readings to 0.01 C or Q24.8 pascal.
// ---------------------------------------------------------------------------
// A sequencer runs the program of a temperature or pressure transaction one
// micro-op per cycle, but holds at the program end while the output register
// is still full; a 64-bit multiply takes three passes through the single
// 32x32 multiplier and the signed divide yields one quotient bit per cycle. A
// zero denominator ends a pressure transaction early. One transaction is
// in work at a time; the next is taken once the result sits in the output
// register. Calibration writes take effect at once and must be made while no
// transaction is in work. Pressure uses the fine temperature of the most
// recent temperature transaction, zero after reset.
module pressure_temp_compensation import pcs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_kind,
   input  logic [RAW_W-1:0]         req_raw_reading,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_result_kind,
   output logic signed [TEMP_W-1:0] rsp_temperature_centi,
   output logic [PRESS_W-1:0]       rsp_pressure_q24_8,
   output logic                     rsp_divide_by_zero,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [COEF_W-1:0]        csr_wdata
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   // sequencer
   pcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic
   pcs_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_kind              (req_kind),
      .req_raw_reading       (req_raw_reading),
      .csr_wen               (csr_valid && csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .rsp_result_kind       (rsp_result_kind),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_pressure_q24_8    (rsp_pressure_q24_8),
      .rsp_divide_by_zero    (rsp_divide_by_zero)
   );

endmodule

>>> rtl/pcs_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcs_ctrl
// Microprogram sequencer: steps through the compensation program, times the
// multi-cycle multiply and divide, and owns the handshakes.
// ---------------------------------------------------------------------------
module pcs_ctrl import pcs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_kind,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type         state_ff, state_in;
   logic [PC_W-1:0]   pc_ff, pc_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   instr_type         instr;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= PC_TEMP;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign instr = prog(pc_ff);

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.run      = 1'b0;
      cmd.load_req = 1'b0;
      cmd.instr    = instr;
      cmd.step     = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               pc_in        = req_kind ? PC_PRESS : PC_TEMP;
               cnt_in       = '0;
               state_in     = ST_RUN;
            end
         end
         ST_RUN: begin
            unique case (instr.op)
               OP_MUL: begin
                  cmd.run = 1'b1;
                  if (cnt_ff == MUL_LAST) begin
                     cnt_in = '0;
                     pc_in  = pc_ff + 1'b1;
                  end else begin
                     cnt_in = cnt_ff + 1'b1;
                  end
               end
               OP_DIV: begin
                  cmd.run = 1'b1;
                  if (cnt_ff == DIV_LAST) begin
                     cnt_in = '0;
                     pc_in  = pc_ff + 1'b1;
                  end else begin
                     cnt_in = cnt_ff + 1'b1;
                  end
               end
               OP_BZ: begin
                  pc_in = status.a_zero ? PC_DZ : pc_ff + 1'b1;
               end
               OP_END_T, OP_END_P, OP_END_Z: begin
                  // wait for the output register to be free
                  if (!rsp_valid_ff || !rsp_stall) begin
                     cmd.run      = 1'b1;
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end
               default: begin
                  cmd.run = 1'b1;
                  pc_in   = pc_ff + 1'b1;
               end
            endcase
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // checks
   a_accept_runs: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_RUN))
      else $error("accepted transaction did not start the program");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= DIV_LAST)
      else $error("step counter out of range");
   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (pc_ff <= PC_LAST))
      else $error("program counter out of range");
   a_rsp_from_run: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RUN))
      else $error("result raised outside of program end");

endmodule

>>> rtl/pcs_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcs_datapath
// 64-bit register file, shared 32x32 multiplier, serial divider, shifter,
// calibration registers and the output register.
// ---------------------------------------------------------------------------
module pcs_datapath import pcs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           status,
   input  logic                 req_kind,
   input  logic [RAW_W-1:0]     req_raw_reading,
   input  logic                 csr_wen,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]    csr_wdata,
   output logic                 rsp_result_kind,
   output logic signed [TEMP_W-1:0] rsp_temperature_centi,
   output logic [PRESS_W-1:0]   rsp_pressure_q24_8,
   output logic                 rsp_divide_by_zero
);

   logic [COEF_W-1:0] tc_ff, pl_ff, pm_ff, ph_ff;
   logic [FINE_W-1:0] fine_ff;
   logic              kind_ff;
   logic [RAW_W-1:0]  adc_ff;
   logic [WORD_W-1:0] rf_ff [4];
   logic [WORD_W-1:0] acc_ff;
   logic [WORD_W-1:0] rem_ff, quo_ff, dvs_ff;
   logic              neg_ff;
   logic              o_kind_ff, o_dz_ff;
   logic [TEMP_W-1:0] o_temp_ff;
   logic [PRESS_W-1:0] o_press_ff;

   logic [WORD_W-1:0] opa, opb, alu, prod, mul_sum;
   logic [HALF_W-1:0] ma, mb;
   logic [WORD_W:0]   trial, diff;
   logic [WORD_W-1:0] abs_a, abs_b;
   logic [TEMP_W-1:0] temp_sat;
   logic [PRESS_W-1:0] press_sat;
   logic              write_rf;

   function automatic logic [WORD_W-1:0] sx16(logic [CW_W-1:0] w);
      return {{(WORD_W-CW_W){w[CW_W-1]}}, w};
   endfunction

   // operand selection
   function automatic logic [WORD_W-1:0] sel(src_type s);
      logic [WORD_W-1:0] v;
      unique case (s)
         SRC_R0:       v = rf_ff[0];
         SRC_R1:       v = rf_ff[1];
         SRC_R2:       v = rf_ff[2];
         SRC_R3:       v = rf_ff[3];
         SRC_ADC:      v = WORD_W'(adc_ff);
         SRC_T1:       v = WORD_W'(tc_ff[15:0]);
         SRC_T2:       v = sx16(tc_ff[31:16]);
         SRC_T3:       v = sx16(tc_ff[47:32]);
         SRC_P1:       v = WORD_W'(pl_ff[15:0]);
         SRC_P2:       v = sx16(pl_ff[31:16]);
         SRC_P3:       v = sx16(pl_ff[47:32]);
         SRC_P4:       v = sx16(pm_ff[15:0]);
         SRC_P5:       v = sx16(pm_ff[31:16]);
         SRC_P6:       v = sx16(pm_ff[47:32]);
         SRC_P7:       v = sx16(ph_ff[15:0]);
         SRC_P8:       v = sx16(ph_ff[31:16]);
         SRC_P9:       v = sx16(ph_ff[47:32]);
         SRC_TFINE:    v = {{(WORD_W-FINE_W){fine_ff[FINE_W-1]}}, fine_ff};
         SRC_K128000:  v = WORD_W'(128000);
         SRC_K1048576: v = WORD_W'(1048576);
         SRC_K3125:    v = WORD_W'(3125);
         SRC_K5:       v = WORD_W'(5);
         SRC_K128:     v = WORD_W'(128);
         SRC_K2P47:    v = WORD_W'(1) << 47;
         default:      v = '0;
      endcase
      return v;
   endfunction

   assign opa = sel(cmd.instr.a);
   assign opb = sel(cmd.instr.b);
   assign status.a_zero = (opa == '0);

   // shared multiplier: low product, then the two cross terms
   always_comb begin
      ma = opa[HALF_W-1:0];
      mb = opb[HALF_W-1:0];
      if (cmd.step == STEP_W'(1)) begin
         mb = opb[WORD_W-1:HALF_W];
      end else if (cmd.step == STEP_W'(2)) begin
         ma = opa[WORD_W-1:HALF_W];
      end
   end
   assign prod    = WORD_W'(ma) * WORD_W'(mb);
   assign mul_sum = (cmd.step == '0) ? prod : acc_ff + {prod[HALF_W-1:0], {HALF_W{1'b0}}};

   // divider step
   assign trial = {rem_ff, quo_ff[WORD_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign abs_a = opa[WORD_W-1] ? ('0 - opa) : opa;
   assign abs_b = opb[WORD_W-1] ? ('0 - opb) : opb;

   // result and register-file write for each operation
   always_comb begin
      write_rf = 1'b0;
      alu      = '0;
      unique case (cmd.instr.op)
         OP_ADD: begin alu = opa + opb; write_rf = 1'b1; end
         OP_SUB: begin alu = opa - opb; write_rf = 1'b1; end
         OP_ASR: begin alu = WORD_W'($signed(opa) >>> cmd.instr.sh); write_rf = 1'b1; end
         OP_SHL: begin alu = opa << cmd.instr.sh; write_rf = 1'b1; end
         OP_MUL: begin alu = mul_sum; write_rf = (cmd.step == MUL_LAST); end
         OP_DIV: begin
            alu      = neg_ff ? ('0 - quo_ff) : quo_ff;
            write_rf = (cmd.step == DIV_LAST);
         end
         default: begin alu = '0; write_rf = 1'b0; end
      endcase
   end

   // saturation of the final value
   always_comb begin
      if ($signed(rf_ff[0]) > $signed(WORD_W'(64'sd8388607))) begin
         temp_sat = TEMP_W'(24'h7FFFFF);
      end else if ($signed(rf_ff[0]) < $signed(-WORD_W'(64'sd8388608))) begin
         temp_sat = TEMP_W'(24'h800000);
      end else begin
         temp_sat = rf_ff[0][TEMP_W-1:0];
      end
      if (rf_ff[0][WORD_W-1]) begin
         press_sat = '0;
      end else if (rf_ff[0][WORD_W-1:PRESS_W] != '0) begin
         press_sat = '1;
      end else begin
         press_sat = rf_ff[0][PRESS_W-1:0];
      end
   end

   // calibration registers and fine temperature
   always_ff @(posedge clock) begin
      if (reset) begin
         tc_ff   <= '0;
         pl_ff   <= '0;
         pm_ff   <= '0;
         ph_ff   <= '0;
         fine_ff <= '0;
      end else begin
         if (csr_wen) begin
            unique case (csr_index)
               CSR_TEMP:   tc_ff <= csr_wdata;
               CSR_P_LOW:  pl_ff <= csr_wdata;
               CSR_P_MID:  pm_ff <= csr_wdata;
               CSR_P_HIGH: ph_ff <= csr_wdata;
               default:    tc_ff <= tc_ff;
            endcase
         end
         if (cmd.run && cmd.instr.op == OP_FINE) begin
            fine_ff <= opa[FINE_W-1:0];
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff <= req_kind;
         adc_ff  <= req_raw_reading;
      end
      if (cmd.run && write_rf) begin
         rf_ff[cmd.instr.dst] <= alu;
      end
      if (cmd.run && cmd.instr.op == OP_MUL) begin
         acc_ff <= mul_sum;
      end
      if (cmd.run && cmd.instr.op == OP_DIV) begin
         if (cmd.step == '0) begin
            rem_ff <= '0;
            quo_ff <= abs_a;
            dvs_ff <= abs_b;
            neg_ff <= opa[WORD_W-1] ^ opb[WORD_W-1];
         end else if (cmd.step != DIV_LAST) begin
            if (!diff[WORD_W]) begin
               rem_ff <= diff[WORD_W-1:0];
               quo_ff <= {quo_ff[WORD_W-2:0], 1'b1};
            end else begin
               rem_ff <= trial[WORD_W-1:0];
               quo_ff <= {quo_ff[WORD_W-2:0], 1'b0};
            end
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.run) begin
         unique case (cmd.instr.op)
            OP_END_T: begin
               o_kind_ff  <= kind_ff;
               o_temp_ff  <= temp_sat;
               o_press_ff <= '0;
               o_dz_ff    <= 1'b0;
            end
            OP_END_P: begin
               o_kind_ff  <= kind_ff;
               o_temp_ff  <= '0;
               o_press_ff <= press_sat;
               o_dz_ff    <= 1'b0;
            end
            OP_END_Z: begin
               o_kind_ff  <= kind_ff;
               o_temp_ff  <= '0;
               o_press_ff <= '0;
               o_dz_ff    <= 1'b1;
            end
            default: o_kind_ff <= o_kind_ff;
         endcase
      end
   end

   assign rsp_result_kind       = o_kind_ff;
   assign rsp_temperature_centi = $signed(o_temp_ff);
   assign rsp_pressure_q24_8    = o_press_ff;
   assign rsp_divide_by_zero    = o_dz_ff;

endmodule

>>> verif/pcs_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcs_checker
// Watches the request, response and calibration channels of the compensation
// block, computes the expected temperature / pressure for every accepted
// request and compares each accepted response field by field, in order.
// ---------------------------------------------------------------------------
module pcs_checker import pcs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic                     req_kind,
   input  logic [RAW_W-1:0]         req_raw_reading,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic                     rsp_result_kind,
   input  logic signed [TEMP_W-1:0] rsp_temperature_centi,
   input  logic [PRESS_W-1:0]       rsp_pressure_q24_8,
   input  logic                     rsp_divide_by_zero,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [COEF_W-1:0]        csr_wdata,
   output int                       fail_count,
   output int                       pending,
   output int                       temp_seen,
   output int                       press_seen,
   output int                       dz_seen
);

   localparam logic KIND_TEMP = 1'b0;

   typedef struct {
      logic                     kind;
      logic signed [TEMP_W-1:0] temp;
      logic [PRESS_W-1:0]       press;
      logic                     dz;
   } reading_type;

   // calibration shadow and kept fine temperature
   logic [COEF_W-1:0] cal_temp, cal_p_low, cal_p_mid, cal_p_high;
   logic [FINE_W-1:0] fine_temp;
   reading_type       expected_readings[$];

   function automatic longint cal_word(logic [COEF_W-1:0] r, int k, bit is_signed);
      logic [CW_W-1:0] w;
      w = r[16*k +: 16];
      return is_signed ? longint'($signed(w)) : longint'({48'd0, w});
   endfunction

   // truncating signed divide on magnitudes, den nonzero
   function automatic longint trunc_div(longint num, longint den);
      longint unsigned mag_n, mag_d, quo;
      mag_n = (num < 0) ? longint'(0) - num : num;
      mag_d = (den < 0) ? longint'(0) - den : den;
      quo   = mag_n / mag_d;
      return ((num < 0) != (den < 0)) ? longint'(0) - longint'(quo) : longint'(quo);
   endfunction

   // expected result of one reading, updates the kept fine temperature
   function automatic reading_type compensate(logic kind, logic [RAW_W-1:0] raw);
      reading_type r;
      longint adc, t1, t2, t3, d1, d2, v1, v2, tf, tc;
      longint p1, p2, p3, p4, p5, p6, p7, p8, p9, a, b, p, q;
      adc     = longint'({44'd0, raw});
      r.kind  = kind;
      r.temp  = '0;
      r.press = '0;
      r.dz    = 1'b0;
      if (kind == KIND_TEMP) begin
         t1 = cal_word(cal_temp, 0, 0);
         t2 = cal_word(cal_temp, 1, 1);
         t3 = cal_word(cal_temp, 2, 1);
         d1 = (adc >>> 3) - (t1 <<< 1);
         v1 = (d1 * t2) >>> 11;
         d2 = (adc >>> 4) - t1;
         v2 = (((d2 * d2) >>> 12) * t3) >>> 14;
         tf = v1 + v2;
         fine_temp = tf[31:0];
         tc = (longint'($signed(tf[31:0])) * 5 + 128) >>> 8;
         if (tc > 8388607) tc = 8388607;
         if (tc < -8388608) tc = -8388608;
         r.temp = tc[TEMP_W-1:0];
      end else begin
         p1 = cal_word(cal_p_low, 0, 0);
         p2 = cal_word(cal_p_low, 1, 1);
         p3 = cal_word(cal_p_low, 2, 1);
         p4 = cal_word(cal_p_mid, 0, 1);
         p5 = cal_word(cal_p_mid, 1, 1);
         p6 = cal_word(cal_p_mid, 2, 1);
         p7 = cal_word(cal_p_high, 0, 1);
         p8 = cal_word(cal_p_high, 1, 1);
         p9 = cal_word(cal_p_high, 2, 1);
         a = longint'($signed(fine_temp)) - 128000;
         b = a * a * p6;
         b = b + ((a * p5) <<< 17);
         b = b + (p4 <<< 35);
         a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
         a = (((longint'(1) <<< 47) + a) * p1) >>> 33;
         if (a == 0) begin
            r.dz = 1'b1;
         end else begin
            p = 1048576 - adc;
            p = trunc_div(((p <<< 31) - b) * 3125, a);
            q = p >>> 13;
            a = (p9 * q * q) >>> 25;
            b = (p8 * p) >>> 19;
            p = ((p + a + b) >>> 8) + (p7 <<< 4);
            if (p < 0) r.press = '0;
            else if (p > 64'sh0FFFF_FFFF) r.press = '1;
            else r.press = p[PRESS_W-1:0];
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         cal_temp   <= '0;
         cal_p_low  <= '0;
         cal_p_mid  <= '0;
         cal_p_high <= '0;
         fine_temp  = '0;
         fail_count = 0;
         temp_seen  = 0;
         press_seen = 0;
         dz_seen    = 0;
         expected_readings.delete();
      end else begin
         // calibration writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TEMP:   cal_temp   <= csr_wdata;
               CSR_P_LOW:  cal_p_low  <= csr_wdata;
               CSR_P_MID:  cal_p_mid  <= csr_wdata;
               CSR_P_HIGH: cal_p_high <= csr_wdata;
               default: ;
            endcase
         end
         // accepted request transaction
         if (req_valid && !req_stall)
            expected_readings.push_back(compensate(req_kind, req_raw_reading));
         // accepted response transaction
         if (rsp_valid && !rsp_stall) begin
            if (expected_readings.size() == 0) begin
               $display("[%0t] response with nothing outstanding", $realtime);
               fail_count++;
            end else begin
               want = expected_readings.pop_front();
               if (rsp_result_kind !== want.kind)
                  report_mismatch("result_kind", rsp_result_kind, want.kind);
               if (rsp_temperature_centi !== want.temp)
                  report_mismatch("temperature_centi", rsp_temperature_centi, want.temp);
               if (rsp_pressure_q24_8 !== want.press)
                  report_mismatch("pressure_q24_8", rsp_pressure_q24_8, want.press);
               if (rsp_divide_by_zero !== want.dz)
                  report_mismatch("divide_by_zero", rsp_divide_by_zero, want.dz);
               if (want.kind == KIND_TEMP) temp_seen++;
               else press_seen++;
               if (want.dz) dz_seen++;
            end
         end
      end
      // outstanding transactions
      pending = expected_readings.size();
   end

endmodule

>>> verif/pressure_temp_compensation_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pressure_temp_compensation_tb
// Drives calibration sets and temperature / pressure readings with random
// gaps and back-pressure; a checker module predicts and compares responses.
// ---------------------------------------------------------------------------
module pressure_temp_compensation_tb import pcs_pkg::*; ();

   localparam logic KIND_TEMP  = 1'b0;
   localparam logic KIND_PRESS = 1'b1;
   localparam int   IDLE_LIMIT = 5000;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic                     req_kind;
   logic [RAW_W-1:0]         req_raw_reading;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic                     rsp_result_kind;
   logic signed [TEMP_W-1:0] rsp_temperature_centi;
   logic [PRESS_W-1:0]       rsp_pressure_q24_8;
   logic                     rsp_divide_by_zero;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [COEF_W-1:0]        csr_wdata;
   int                       fail_count, pending, temp_seen, press_seen, dz_seen;
   int                       idle_cycles;
   int                       hold_left;
   bit                       long_hold_due;
   int                       readings_sent;

   pressure_temp_compensation dut (.*);

   pcs_checker checker_i (.*);

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // response back-pressure: short random stalls, rare long holds
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (long_hold_due) begin
         long_hold_due = 1'b0;
         rsp_stall <= 1'b1;
         hold_left <= 600;
      end else if ($urandom_range(0, 999) == 0) begin
         rsp_stall <= 1'b1;
         hold_left <= $urandom_range(100, 300);
      end else begin
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end
   end

   // watchdog on cycles without any accepted transaction
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int gap_length();
      return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
   endfunction

   task automatic write_cal(logic [CSR_IDX_W-1:0] idx, logic [COEF_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_cal(logic [COEF_W-1:0] t, logic [COEF_W-1:0] pl,
                           logic [COEF_W-1:0] pm, logic [COEF_W-1:0] ph);
      write_cal(CSR_TEMP, t);
      write_cal(CSR_P_LOW, pl);
      write_cal(CSR_P_MID, pm);
      write_cal(CSR_P_HIGH, ph);
   endtask

   // one request transaction; valid stays high across back-to-back items
   task automatic send_reading(logic kind, logic [RAW_W-1:0] raw, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_raw_reading <= raw;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      readings_sent++;
   endtask

   task automatic drain();
      @(posedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   function automatic logic [RAW_W-1:0] random_raw();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return RAW_W'($urandom_range(400000, 600000));
         default: return RAW_W'($urandom);
      endcase
   endfunction

   function automatic logic [COEF_W-1:0] random_cal();
      return {$urandom, $urandom};
   endfunction

   task automatic random_readings(int count);
      repeat (count) begin
         send_reading(($urandom_range(0, 2) == 0) ? KIND_TEMP : KIND_PRESS,
                      random_raw(), gap_length());
      end
      drain();
   endtask

   task automatic directed_readings();
      send_reading(KIND_PRESS, 20'd415148, 0);
      send_reading(KIND_TEMP, '0, 0);
      send_reading(KIND_TEMP, '1, 0);
      send_reading(KIND_TEMP, 20'd519888, 1);
      send_reading(KIND_PRESS, '0, 0);
      send_reading(KIND_PRESS, '1, 0);
      send_reading(KIND_PRESS, 20'd415148, 3);
      drain();
   endtask

   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_kind        = KIND_TEMP;
      req_raw_reading = '0;
      csr_valid       = 1'b0;
      csr_index       = CSR_TEMP;
      csr_wdata       = '0;
      long_hold_due   = 1'b0;
      readings_sent   = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset calibration: every pressure hits the zero denominator
      directed_readings();
      random_readings(60);

      // typical factory calibration, pressure before any new temperature
      load_cal({16'hFC18, 16'd26435, 16'd27504}, {16'd3024, 16'hD643, 16'd36477},
               {16'hFFF9, 16'd140, 16'd2855}, {16'd6000, 16'hC6F8, 16'd15500});
      directed_readings();
      long_hold_due = 1'b1;
      random_readings(250);

      // all ones
      load_cal('1, '1, '1, '1);
      directed_readings();
      random_readings(80);

      // most negative signed words, largest unsigned ones
      load_cal({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h8000, 16'hFFFF},
               {16'h8000, 16'h8000, 16'h8000}, {16'h8000, 16'h8000, 16'h8000});
      directed_readings();
      random_readings(60);

      // most positive signed words
      load_cal({16'h7FFF, 16'h7FFF, 16'h0001}, {16'h7FFF, 16'h7FFF, 16'h0001},
               {16'h7FFF, 16'h7FFF, 16'h7FFF}, {16'h7FFF, 16'h7FFF, 16'h7FFF});
      directed_readings();
      random_readings(60);

      // P1 zero forces the zero denominator with other words live
      load_cal({16'hFC18, 16'd26435, 16'd27504}, {16'd3024, 16'hD643, 16'd0},
               {16'hFFF9, 16'd140, 16'd2855}, {16'd6000, 16'hC6F8, 16'd15500});
      random_readings(40);

      // random calibration sets
      repeat (6) begin
         load_cal(random_cal(), random_cal(), random_cal(), random_cal());
         random_readings(45);
      end

      repeat (150) @(posedge clock);
      $display("covered %0d readings: %0d temperature, %0d pressure, %0d zero denominators",
               readings_sent, temp_seen, press_seen, dz_seen);
      $display("over 12 calibration sets including zero, all-ones and signed extremes");
      if (fail_count == 0 && pending == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
